// ===== sv/ismu_pkg.sv =====
// Shared types, constants and helpers of the I/Q sample magnitude unit.
// No dependencies; every other file imports this package.
package ismu_pkg;

  // Field widths fixed by the sample format.
  localparam int unsigned SmplW = 16;
  localparam int unsigned AbsW  = 15;
  localparam int unsigned MagW  = 16;

  // Q15 coefficients of the two-segment max/min approximation.
  localparam logic [AbsW-1:0] QThresh = 15'd13572;
  localparam logic [AbsW-1:0] QAHi    = 15'd27525;
  localparam logic [AbsW-1:0] QBHi    = 15'd18382;
  localparam logic [AbsW-1:0] QALo    = 15'd32440;
  localparam logic [AbsW-1:0] QBLo    = 15'd6455;
  localparam logic [AbsW-1:0] SatMax  = 15'd32767;

  // Method codes of the mode register.
  localparam logic ModeExact  = 1'b0;
  localparam logic ModeApprox = 1'b1;

  // Back end: stages before the root and one stage per root bit.
  localparam int unsigned PreStg    = 4;
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned BackStg   = PreStg + SqrtSteps;

  // Classified sample as it waits in the queue.
  typedef struct packed {
    logic             mode;
    logic             last;
    logic [SmplW-1:0] abs_i;
    logic [SmplW-1:0] abs_q;
    logic [AbsW-1:0]  mn;
    logic [AbsW-1:0]  mx;
  } ismu_ent_t;

  // Word carried through the square root stages.
  typedef struct packed {
    logic            mode;
    logic            last;
    logic            sat;
    logic [MagW-1:0] approx;
    logic [31:0]     rem;
    logic [31:0]     root;
  } ismu_sq_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } ismu_qstat_t;

  // Absolute value of a two's complement sample; the most negative code
  // maps to 32768, which still fits the unsigned result.
  function automatic logic [SmplW-1:0] abs_full(input logic [SmplW-1:0] x);
    return x[SmplW-1] ? (~x + 16'd1) : x;
  endfunction

endpackage

// ===== sv/ismu_front.sv =====
// Front end of the magnitude unit: accepts sample words and classifies them.
// Depends on ismu_pkg for the queue entry type and the absolute value helper.
module ismu_front import ismu_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            mode,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [31:0]     in_tdata,   // i_sample [15:0], q_sample [31:16]
  input  logic            in_tlast,   // last_in
  output logic            push,
  output ismu_ent_t       push_ent,
  input  logic            q_ready
);

  logic             front_v_r, front_v_nxt;
  ismu_ent_t        front_ent_r, front_ent_nxt;
  logic [SmplW-1:0] ai, aq;
  logic [AbsW-1:0]  sai, saq;

  // The holding register frees up whenever the queue takes its word.
  assign in_tready = !front_v_r || q_ready;
  assign push      = front_v_r;
  assign push_ent  = front_ent_r;

  // Full and saturated absolute values, then min and max of the latter.
  always_comb begin
    ai  = abs_full(in_tdata[SmplW-1:0]);
    aq  = abs_full(in_tdata[2*SmplW-1:SmplW]);
    sai = ai[SmplW-1] ? SatMax : ai[AbsW-1:0];
    saq = aq[SmplW-1] ? SatMax : aq[AbsW-1:0];
    front_ent_nxt.mode  = mode;
    front_ent_nxt.last  = in_tlast;
    front_ent_nxt.abs_i = ai;
    front_ent_nxt.abs_q = aq;
    front_ent_nxt.mn    = (sai < saq) ? sai : saq;
    front_ent_nxt.mx    = (sai < saq) ? saq : sai;
    front_v_nxt = in_tready ? in_tvalid : front_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      front_ent_r <= front_ent_nxt;
    end
  end

endmodule

// ===== sv/ismu_queue.sv =====
// Short queue between the front and back ends of the magnitude unit.
// Depends on ismu_pkg for the entry and status types.
module ismu_queue import ismu_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  ismu_ent_t   wr_ent,
  output logic        rd_valid,
  input  logic        rd_ready,
  output ismu_ent_t   rd_ent,
  output ismu_qstat_t stat
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ismu_ent_t       mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            wr_en, rd_en;

  assign wr_ready   = (cnt_r != CntW'(DEPTH));
  assign rd_valid   = (cnt_r != '0);
  assign wr_en      = wr_valid && wr_ready;
  assign rd_en      = rd_ready && rd_valid;
  assign rd_ent     = mem_r[rd_ptr_r];
  assign stat.full  = !wr_ready;
  assign stat.empty = !rd_valid;

  // Pointer wrap and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage is written only; it needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_ent;
    end
  end

endmodule

// ===== sv/ismu_back.sv =====
// Back end of the magnitude unit: multiplier stages, approximation and a
// one-bit-per-stage square root pipeline. Depends on ismu_pkg.
module ismu_back import ismu_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  ismu_ent_t       q_ent,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,  // magnitude [15:0]
  output logic            out_tlast,  // last_out
  output logic            out_mode
);

  logic            adv;
  logic [BackStg-1:0] vld_r, vld_nxt;

  // Stage 1: squares and the threshold product.
  logic            s1_mode_r, s1_last_r;
  logic [31:0]     s1_sqi_r, s1_sqq_r, s1_sqi_nxt, s1_sqq_nxt;
  logic [28:0]     s1_thp_r, s1_thp_nxt;
  logic [AbsW-1:0] s1_mn_r, s1_mx_r;

  // Stage 2: sum of squares and coefficient choice.
  logic            s2_mode_r, s2_last_r;
  logic [32:0]     s2_sum_nxt;
  logic [31:0]     s2_sum_r;
  logic [29:0]     th_w;
  logic            seg_hi;
  logic [AbsW-1:0] s2_ca_r, s2_cb_r, s2_ca_nxt, s2_cb_nxt, s2_mn_r, s2_mx_r;

  // Stage 3: approximation products and the radicand.
  logic            s3_mode_r, s3_last_r, s3_sat_r, s3_sat_nxt;
  logic [29:0]     s3_pa_r, s3_pb_r, s3_pa_nxt, s3_pb_nxt;
  logic [31:0]     s3_rad_r, s3_rad_nxt;

  // Stage 4: rounded sum for the approximation; seeds the root.
  logic [30:0]     ra_w, rb_w;
  logic [16:0]     s_w;
  logic [AbsW-1:0] s_sat;
  ismu_sq_t        s4_r, s4_nxt;

  // Root stages.
  ismu_sq_t        sq_in  [SqrtSteps];
  ismu_sq_t        sq_r   [SqrtSteps];
  ismu_sq_t        sq_nxt [SqrtSteps];
  ismu_sq_t        fin;

  // The whole pipeline moves together unless the output word is stuck.
  assign adv   = !vld_r[BackStg-1] || out_tready;
  assign q_pop = adv;

  always_comb begin
    vld_nxt = adv ? {vld_r[BackStg-2:0], q_valid} : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1 logic.
  always_comb begin
    s1_sqi_nxt = 32'(q_ent.abs_i) * 32'(q_ent.abs_i);
    s1_sqq_nxt = 32'(q_ent.abs_q) * 32'(q_ent.abs_q);
    s1_thp_nxt = 29'(q_ent.mx) * 29'(QThresh);
  end

  // Stage 2 logic: th = round(2*mx*c / 65536) = (p + 16384) >> 15.
  always_comb begin
    s2_sum_nxt = {1'b0, s1_sqi_r} + {1'b0, s1_sqq_r};
    th_w       = {1'b0, s1_thp_r} + 30'd16384;
    seg_hi     = (s1_mn_r >= th_w[29:15]);
    s2_ca_nxt  = seg_hi ? QAHi : QALo;
    s2_cb_nxt  = seg_hi ? QBHi : QBLo;
  end

  // Stage 3 logic: sum of squares at or above 2^30 saturates the root.
  always_comb begin
    s3_pa_nxt  = 30'(s2_mx_r) * 30'(s2_ca_r);
    s3_pb_nxt  = 30'(s2_mn_r) * 30'(s2_cb_r);
    s3_sat_nxt = (s2_sum_r[31:30] != 2'b00);
    s3_rad_nxt = {s2_sum_r[29:0], 2'b00};
  end

  // Stage 4 logic: rounded products, saturating add, doubling.
  always_comb begin
    ra_w  = {1'b0, s3_pa_r} + 31'd16384;
    rb_w  = {1'b0, s3_pb_r} + 31'd16384;
    s_w   = {1'b0, ra_w[30:15]} + {1'b0, rb_w[30:15]};
    s_sat = (s_w > {2'b00, SatMax}) ? SatMax : s_w[AbsW-1:0];
    s4_nxt.mode   = s3_mode_r;
    s4_nxt.last   = s3_last_r;
    s4_nxt.sat    = s3_sat_r;
    s4_nxt.approx = {s_sat, 1'b0};
    s4_nxt.rem    = s3_rad_r;
    s4_nxt.root   = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r <= q_ent.mode;
      s1_last_r <= q_ent.last;
      s1_sqi_r  <= s1_sqi_nxt;
      s1_sqq_r  <= s1_sqq_nxt;
      s1_thp_r  <= s1_thp_nxt;
      s1_mn_r   <= q_ent.mn;
      s1_mx_r   <= q_ent.mx;
      s2_mode_r <= s1_mode_r;
      s2_last_r <= s1_last_r;
      s2_sum_r  <= s2_sum_nxt[31:0];
      s2_ca_r   <= s2_ca_nxt;
      s2_cb_r   <= s2_cb_nxt;
      s2_mn_r   <= s1_mn_r;
      s2_mx_r   <= s1_mx_r;
      s3_mode_r <= s2_mode_r;
      s3_last_r <= s2_last_r;
      s3_sat_r  <= s3_sat_nxt;
      s3_pa_r   <= s3_pa_nxt;
      s3_pb_r   <= s3_pb_nxt;
      s3_rad_r  <= s3_rad_nxt;
      s4_r      <= s4_nxt;
    end
  end

  // One root bit per stage: subtract root+bit when it fits.
  always_comb begin
    logic [32:0] trial;
    logic [31:0] bitv;
    for (int i = 0; i < SqrtSteps; i++) begin
      sq_in[i]  = (i == 0) ? s4_r : sq_r[(i == 0) ? 0 : i - 1];
      bitv      = 32'd1 << (2 * (SqrtSteps - 1 - i));
      trial     = {1'b0, sq_in[i].root} + {1'b0, bitv};
      sq_nxt[i] = sq_in[i];
      if ({1'b0, sq_in[i].rem} >= trial) begin
        sq_nxt[i].rem  = sq_in[i].rem - trial[31:0];
        sq_nxt[i].root = (sq_in[i].root >> 1) + bitv;
      end else begin
        sq_nxt[i].root = sq_in[i].root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < SqrtSteps; i++) begin
        sq_r[i] <= sq_nxt[i];
      end
    end
  end

  // Output word from the last stage.
  assign fin        = sq_r[SqrtSteps-1];
  assign out_tvalid = vld_r[BackStg-1];
  assign out_tlast  = fin.last;
  assign out_mode   = fin.mode;

  always_comb begin
    if (fin.mode == ModeApprox) begin
      out_tdata = fin.approx;
    end else if (fin.sat) begin
      out_tdata = '1;
    end else begin
      out_tdata = fin.root[MagW-1:0];
    end
  end

endmodule

// ===== sv/iq_sample_magnitude_unit.sv =====
// Magnitude of one signed 16-bit I/Q sample per word, exact root or max/min approximation.
// Path from input acceptance to output valid: input register, queue, then
// 20 back-end stages of which 16 are square root bit stages.
// Throughput: one word per cycle unless out_tready holds the output; every back-end stage is fully pipelined.
// Reset (synchronous, active low) empties all stages and the queue and selects exact mode.
// Depends on ismu_pkg, ismu_front, ismu_queue and ismu_back.
module iq_sample_magnitude_unit import ismu_pkg::*; #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,  // method_mode
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // i_sample [15:0], q_sample [31:16]
  input  logic        in_tlast,     // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // magnitude [15:0]
  output logic        out_tlast     // last_out
);

  logic        mode_r, mode_nxt;
  logic        push, q_wr_ready, q_rd_valid, q_pop, out_mode;
  ismu_ent_t   push_ent, q_ent;
  ismu_qstat_t q_stat;

  // Method register.
  assign mode_nxt = cfg_wr_en ? cfg_wr_data : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeExact;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  ismu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push      (push),
    .push_ent  (push_ent),
    .q_ready   (q_wr_ready)
  );

  ismu_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push),
    .wr_ready (q_wr_ready),
    .wr_ent   (push_ent),
    .rd_valid (q_rd_valid),
    .rd_ready (q_pop),
    .rd_ent   (q_ent),
    .stat     (q_stat)
  );

  ismu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_rd_valid),
    .q_pop      (q_pop),
    .q_ent      (q_ent),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_mode   (out_mode)
  );

  // The pipeline holds no word in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  // The queue is never full and empty at once.
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({q_stat.full, q_stat.empty}))
    else $error("queue reports full and empty together");

  // The input stalls only when the front word is held by a full queue.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (push && q_stat.full))
    else $error("input stalled without a full queue");

  // The approximation always yields an even magnitude.
  a_approx_even: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_mode == ModeApprox) |-> (out_tdata[0] == 1'b0))
    else $error("approximate magnitude is odd");

endmodule
